FILE: hdl/gf2_subspace_rref_key_defines.svh
// assertion macros for the gf2 subspace key block
`ifndef GF2_SUBSPACE_RREF_KEY_DEFINES_SVH
`define GF2_SUBSPACE_RREF_KEY_DEFINES_SVH

// same-cycle implication, held off during reset
`define GF2SRK_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define GF2SRK_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/gf2srk_pkg.sv
// shared types, constants and helper functions of the gf2 subspace key block
package gf2srk_pkg;

  localparam int VECTOR_BITS   = 9;
  localparam int ROW_BITS      = 9;
  localparam int PACK_BITS     = 9;
  localparam int DIM_BITS      = 4;
  localparam int KEY_LOW_BITS  = 64;
  localparam int KEY_HIGH_BITS = 21;
  localparam int KEY_BITS      = KEY_LOW_BITS + KEY_HIGH_BITS;
  localparam int ACC_BITS      = PACK_BITS * VECTOR_BITS;
  localparam int PCNT_BITS     = (VECTOR_BITS > 1) ? $clog2(VECTOR_BITS) : 1;

  typedef logic [VECTOR_BITS-1:0] row_t;
  typedef row_t [VECTOR_BITS-1:0] rows_t;

  typedef struct packed {
    logic upd;
    logic shift;
    row_t rem;
    row_t top_oh;
  } cell_ctrl_t;

  // one-hot of the highest set bit, zero for a zero row
  function automatic row_t top_onehot(input row_t v);
    row_t oh;
    logic found;
    oh    = '0;
    found = 1'b0;
    for (int i = VECTOR_BITS - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        oh[i] = 1'b1;
        found = 1'b1;
      end
    end
    return oh;
  endfunction

  // every stored row leads with its own pivot bit and is clear at other pivots
  function automatic logic basis_ok(input rows_t rows);
    logic ok;
    ok = 1'b1;
    for (int p = 0; p < VECTOR_BITS; p++) begin
      if (rows[p] != '0) begin
        if (top_onehot(rows[p]) != (row_t'(1) << p)) ok = 1'b0;
        for (int q = 0; q < VECTOR_BITS; q++) begin
          if (q != p && rows[q] != '0 && rows[p][q]) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

FILE: hdl/gf2srk_if.sv
// valid/ready channel interfaces for input rows and output keys
interface gf2srk_in_if;
  import gf2srk_pkg::*;

  logic                valid;
  logic                ready;
  logic [ROW_BITS-1:0] row_vector;
  logic                last_row;

  modport source (output valid, output row_vector, output last_row, input ready);
  modport sink   (input valid, input row_vector, input last_row, output ready);
endinterface

interface gf2srk_out_if;
  import gf2srk_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KEY_LOW_BITS-1:0]  key_low;
  logic [KEY_HIGH_BITS-1:0] key_high;
  logic [DIM_BITS-1:0]      dimension;

  modport source (output valid, output key_low, output key_high, output dimension,
                  input ready);
  modport sink   (input valid, input key_low, input key_high, input dimension,
                  output ready);
endinterface

FILE: hdl/gf2_subspace_rref_key.sv
// top level of the gf2 subspace key block: cell chain, sequencer, packer, output register
//
// Each row takes two steps: in the cycle it is accepted it runs down the chain of pivot
// cells, each cell clearing its own pivot bit, and the remainder is registered; in the
// next cycle its top bit is cleared from the other cells and it is stored in its slot.
// A row marked last then shifts the basis out through the bottom cell into the packer
// (lowest pivot first), which empties the basis as it goes, and then loads the key
// into the output register, waiting while an earlier key is still held there. Rows are
// accepted only between these steps; a waiting key does not hold up rows that are not
// marked last.
`include "gf2_subspace_rref_key_defines.svh"

module gf2_subspace_rref_key (
  input  logic         clk,
  input  logic         rst_n,
  gf2srk_in_if.sink    in_ch,
  gf2srk_out_if.source out_ch
);
  import gf2srk_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_PACK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [PCNT_BITS-1:0] pack_cnt_r;
  logic [PCNT_BITS-1:0] pack_cnt_nxt;
  row_t                 rem_r;
  logic                 last_r;

  logic                     out_valid_r;
  logic [KEY_LOW_BITS-1:0]  key_low_r;
  logic [KEY_HIGH_BITS-1:0] key_high_r;
  logic [DIM_BITS-1:0]      dim_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 load_out;
  cell_ctrl_t           ctrl;
  row_t [VECTOR_BITS:0] red;
  row_t [VECTOR_BITS:0] shift_bus;
  rows_t                rows;
  logic [KEY_BITS-1:0]  key;
  logic [DIM_BITS-1:0]  count;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_out    = (state_r == ST_EMIT) && out_free;

  assign red[VECTOR_BITS]       = in_ch.row_vector[VECTOR_BITS-1:0];
  assign shift_bus[VECTOR_BITS] = '0;

  assign ctrl.upd    = (state_r == ST_UPD) && (rem_r != '0);
  assign ctrl.shift  = (state_r == ST_PACK);
  assign ctrl.rem    = rem_r;
  assign ctrl.top_oh = top_onehot(rem_r);

  for (genvar p = 0; p < VECTOR_BITS; p++) begin : g_cell
    gf2srk_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .pos_oh   (row_t'(1) << p),
      .ctrl     (ctrl),
      .red_in   (red[p+1]),
      .red_out  (red[p]),
      .shift_in (shift_bus[p+1]),
      .row_q    (shift_bus[p])
    );
    assign rows[p] = shift_bus[p];
  end

  gf2srk_pack u_pack (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  ((state_r == ST_UPD) && last_r),
    .step   (state_r == ST_PACK),
    .row_in (rows[0]),
    .key    (key),
    .count  (count)
  );

  always_comb begin
    state_nxt    = state_r;
    pack_cnt_nxt = pack_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        pack_cnt_nxt = '0;
        state_nxt    = last_r ? ST_PACK : ST_IDLE;
      end
      ST_PACK: begin
        pack_cnt_nxt = pack_cnt_r + PCNT_BITS'(1);
        if (pack_cnt_r == PCNT_BITS'(VECTOR_BITS - 1)) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pack_cnt_r  <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pack_cnt_r <= pack_cnt_nxt;
      if (in_fire) last_r <= in_ch.last_row;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // remainder after the chain, and the output payload
  always_ff @(posedge clk) begin
    if (in_fire) rem_r <= red[0];
    if (load_out) begin
      key_low_r  <= key[KEY_LOW_BITS-1:0];
      key_high_r <= key[KEY_BITS-1:KEY_LOW_BITS];
      dim_r      <= count;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.key_low   = key_low_r;
  assign out_ch.key_high  = key_high_r;
  assign out_ch.dimension = dim_r;

  `GF2SRK_ASSERT_NXT(a_accept_blocks, clk, rst_n, in_fire, !in_ch.ready,
    "row accepted while the previous one was still being stored")
  `GF2SRK_ASSERT_IMP(a_basis_form, clk, rst_n, state_r == ST_IDLE, basis_ok(rows),
    "stored basis is not in reduced echelon form")
  `GF2SRK_ASSERT_IMP(a_cleared_at_emit, clk, rst_n, state_r == ST_EMIT, rows == '0,
    "basis not empty after shifting out")
  `GF2SRK_ASSERT_IMP(a_dim_range, clk, rst_n, out_valid_r,
    dim_r <= DIM_BITS'(VECTOR_BITS) && key_low_r[DIM_BITS-1:0] == dim_r,
    "key dimension out of range or inconsistent")
endmodule

FILE: hdl/gf2srk_cell.sv
// one pivot slot: reduces the passing row, takes back-substitution, shifts out
module gf2srk_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gf2srk_pkg::row_t       pos_oh,
  input  gf2srk_pkg::cell_ctrl_t ctrl,
  input  gf2srk_pkg::row_t       red_in,
  output gf2srk_pkg::row_t       red_out,
  input  gf2srk_pkg::row_t       shift_in,
  output gf2srk_pkg::row_t       row_q
);
  import gf2srk_pkg::*;

  row_t row_r;
  row_t row_nxt;
  logic has_row;
  logic is_top;

  assign has_row = (row_r != '0);
  assign is_top  = ((ctrl.top_oh & pos_oh) != '0);

  // clear this slot's pivot bit from the passing row
  assign red_out = (has_row && ((red_in & pos_oh) != '0)) ? (red_in ^ row_r) : red_in;

  always_comb begin
    row_nxt = row_r;
    priority if (ctrl.shift) begin
      row_nxt = shift_in;
    end else if (ctrl.upd) begin
      if (is_top) begin
        row_nxt = ctrl.rem;
      end else if (has_row && ((row_r & ctrl.top_oh) != '0)) begin
        row_nxt = row_r ^ ctrl.rem;
      end
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;
endmodule

FILE: hdl/gf2srk_pack.sv
// key packer: collects non-zero rows as they leave the bottom cell
module gf2srk_pack (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                clear,
  input  logic                                step,
  input  gf2srk_pkg::row_t                    row_in,
  output logic [gf2srk_pkg::KEY_BITS-1:0]     key,
  output logic [gf2srk_pkg::DIM_BITS-1:0]     count
);
  import gf2srk_pkg::*;

  logic [ACC_BITS-1:0] acc_r;
  logic [ACC_BITS-1:0] acc_nxt;
  logic [DIM_BITS-1:0] count_r;
  logic [DIM_BITS-1:0] count_nxt;

  // lowest pivot leaves first, so it ends up in the highest slot
  always_comb begin
    acc_nxt   = acc_r;
    count_nxt = count_r;
    priority if (clear) begin
      acc_nxt   = '0;
      count_nxt = '0;
    end else if (step && row_in != '0) begin
      acc_nxt   = (acc_r << PACK_BITS) | ACC_BITS'(row_in);
      count_nxt = count_r + DIM_BITS'(1);
    end else begin
      acc_nxt   = acc_r;
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      count_r <= '0;
    end else begin
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
    end
  end

  assign key   = (KEY_BITS'(acc_r) << DIM_BITS) | KEY_BITS'(count_r);
  assign count = count_r;
endmodule

FILE: test/gf2srk_key_checker.sv
// checker for the gf2 subspace key block: tracks the row basis, predicts each key, compares
module gf2srk_key_checker (
  input  logic  clk,
  input  logic  rst_n,
  gf2srk_in_if  in_ch,
  gf2srk_out_if out_ch,
  output int    fail_count,
  output int    keys_pending,
  output int    keys_checked,
  output int    full_rank_keys
);
  timeunit 1ns;
  timeprecision 1ps;
  import gf2srk_pkg::*;

  localparam int KEY_SLOTS = 8;

  typedef logic [KEY_BITS-1:0] key_bits_t;

  typedef struct packed {
    logic [KEY_LOW_BITS-1:0]  key_low;
    logic [KEY_HIGH_BITS-1:0] key_high;
    logic [DIM_BITS-1:0]      dimension;
  } subspace_key_t;

  row_t          echelon_rows [VECTOR_BITS];
  subspace_key_t key_fifo [KEY_SLOTS];
  logic [2:0]    key_head;
  logic [2:0]    key_tail;
  int            key_count;

  // reduce against stored pivots, then make the remainder a new pivot row
  function automatic void fold_row(input row_t v);
    row_t r;
    int   top;
    r   = v;
    top = -1;
    for (int p = VECTOR_BITS - 1; p >= 0; p--) begin
      if (echelon_rows[p] != '0 && r[p]) r ^= echelon_rows[p];
    end
    if (r == '0) return;
    for (int p = VECTOR_BITS - 1; p >= 0; p--) begin
      if (top < 0 && r[p]) top = p;
    end
    for (int p = 0; p < VECTOR_BITS; p++) begin
      if (echelon_rows[p] != '0 && echelon_rows[p][top]) echelon_rows[p] ^= r;
    end
    echelon_rows[top] = r;
  endfunction

  // dimension nibble, then the non-zero rows from the highest pivot down
  function automatic subspace_key_t subspace_key();
    key_bits_t     packed_key;
    int            rank;
    subspace_key_t k;
    packed_key = '0;
    rank       = 0;
    for (int p = VECTOR_BITS - 1; p >= 0; p--) begin
      if (echelon_rows[p] != '0) begin
        packed_key |= key_bits_t'(echelon_rows[p]) << (DIM_BITS + PACK_BITS * rank);
        rank++;
      end
    end
    packed_key[DIM_BITS-1:0] = DIM_BITS'(rank);
    k.key_low   = packed_key[KEY_LOW_BITS-1:0];
    k.key_high  = packed_key[KEY_BITS-1:KEY_LOW_BITS];
    k.dimension = DIM_BITS'(rank);
    return k;
  endfunction

  always @(posedge clk) begin
    subspace_key_t want;
    if (!rst_n) begin
      for (int p = 0; p < VECTOR_BITS; p++) echelon_rows[p] = '0;
      key_head       = '0;
      key_tail       = '0;
      key_count      = 0;
      fail_count     = 0;
      keys_pending   = 0;
      keys_checked   = 0;
      full_rank_keys = 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (key_count == 0) begin
          $display("%0t: key transaction with no row set pending: low %h high %h dim %0d",
                   $realtime, out_ch.key_low, out_ch.key_high, out_ch.dimension);
          fail_count++;
        end else begin
          want      = key_fifo[key_head];
          key_head  = key_head + 3'd1;
          key_count = key_count - 1;
          keys_checked++;
          if (want.dimension == VECTOR_BITS) full_rank_keys++;
          if (out_ch.key_low !== want.key_low) begin
            $display("%0t: key_low mismatch: expected %h actual %h",
                     $realtime, want.key_low, out_ch.key_low);
            fail_count++;
          end
          if (out_ch.key_high !== want.key_high) begin
            $display("%0t: key_high mismatch: expected %h actual %h",
                     $realtime, want.key_high, out_ch.key_high);
            fail_count++;
          end
          if (out_ch.dimension !== want.dimension) begin
            $display("%0t: dimension mismatch: expected %0d actual %0d",
                     $realtime, want.dimension, out_ch.dimension);
            fail_count++;
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        fold_row(row_t'(in_ch.row_vector));
        if (in_ch.last_row === 1'b1) begin
          if (key_count >= KEY_SLOTS) begin
            $display("%0t: more than %0d keys outstanding", $realtime, KEY_SLOTS);
            fail_count++;
          end else begin
            key_fifo[key_tail] = subspace_key();
            key_tail           = key_tail + 3'd1;
            key_count          = key_count + 1;
          end
          for (int p = 0; p < VECTOR_BITS; p++) echelon_rows[p] = '0;
        end
      end
      keys_pending = key_count;
    end
  end

endmodule

FILE: test/tb_top.sv
// top of the gf2 subspace key testbench: clock, reset, row sets, output stalls and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gf2srk_pkg::*;

  localparam int RANDOM_ROWS  = 1800;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 2 * VECTOR_BITS + 8;
  localparam int MAX_SET_ROWS = 24;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   keys_pending;
  int   keys_checked;
  int   full_rank_keys;
  int   rows_sent;
  int   sets_sent;
  int   idle_cycles;

  gf2srk_in_if  in_ch ();
  gf2srk_out_if out_ch ();

  gf2_subspace_rref_key i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gf2srk_key_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .keys_pending   (keys_pending),
    .keys_checked   (keys_checked),
    .full_rank_keys (full_rank_keys)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic send_row(input row_t row, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.row_vector <= row;
    in_ch.last_row   <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    rows_sent++;
    if (last) sets_sent++;
  endtask

  // key sink: stretches of always ready, random ready and full stall
  initial begin
    int mode;
    int span;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(99);
      span = $urandom_range(40, 5);
      repeat (span) begin
        if (mode < 40) out_ch.ready <= 1'b1;
        else if (mode < 85) out_ch.ready <= 1'($urandom_range(1));
        else out_ch.ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                 (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t set_rows [MAX_SET_ROWS];
    int   set_count;
    row_t row;
    int   set_len;
    int   pick;
    int   random_start;

    rows_sent        = 0;
    sets_sent        = 0;
    set_count        = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.row_vector <= '0;
    in_ch.last_row   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty set, then the all-ones row alone
    send_row('0, 1'b1);
    send_row('1, 1'b1);
    // every unit vector, closed by a zero row: full rank
    for (int p = VECTOR_BITS - 1; p >= 0; p--) send_row(row_t'(1) << p, 1'b0);
    send_row('0, 1'b1);
    // repeated row reduces to nothing
    send_row(row_t'(9'h1ff), 1'b0);
    send_row(row_t'(9'h1ff), 1'b0);
    send_row(row_t'(9'h0ff), 1'b1);
    // staircase: each new pivot is eliminated from the rows above it
    for (int p = VECTOR_BITS; p >= 1; p--) send_row(row_t'((1 << p) - 1), p == 1);

    random_start = rows_sent;
    while (rows_sent - random_start < RANDOM_ROWS) begin
      pick = $urandom_range(99);
      if (pick < 60) set_len = $urandom_range(6, 1);
      else if (pick < 85) set_len = $urandom_range(14, 7);
      else set_len = $urandom_range(MAX_SET_ROWS, 15);
      set_count = 0;
      for (int i = 0; i < set_len; i++) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          row = row_t'($urandom);
        end else if (pick < 70) begin
          row = row_t'($urandom) & row_t'($urandom) & row_t'($urandom);
        end else if (pick < 90 && set_count > 0) begin
          // linear combination of earlier rows, so it must vanish
          row = set_rows[$urandom_range(set_count - 1)] ^
                set_rows[$urandom_range(set_count - 1)];
        end else begin
          row = '0;
        end
        set_rows[set_count] = row;
        set_count++;
        send_row(row, i == set_len - 1);
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (keys_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d rows in %0d sets; %0d keys compared, %0d of full rank",
             rows_sent, sets_sent, keys_checked, full_rank_keys);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
